/* sv/tcsm_pkg.sv */
`default_nettype none

package tcsm_pkg;

    // Field widths
    localparam int SEQ_W    = 32;
    localparam int FLAGS_W  = 3;
    localparam int REQ_W    = 2;
    localparam int STATE_W  = 4;
    localparam int CFG_IDX_W = 2;

    // Default depth of the queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Request types
    localparam logic [REQ_W-1:0] REQ_SEGMENT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_ACTIVE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_PASSIVE = 2'd2;
    localparam logic [REQ_W-1:0] REQ_CLOSE   = 2'd3;

    // Segment flags
    localparam logic [FLAGS_W-1:0] FL_NONE    = 3'b000;
    localparam logic [FLAGS_W-1:0] FL_FIN     = 3'b001;
    localparam logic [FLAGS_W-1:0] FL_SYN     = 3'b010;
    localparam logic [FLAGS_W-1:0] FL_ACK     = 3'b100;
    localparam logic [FLAGS_W-1:0] FL_SYN_ACK = 3'b110;
    localparam logic [FLAGS_W-1:0] FL_FIN_ACK = 3'b101;

    // Connection states
    localparam logic [STATE_W-1:0] ST_CLOSED         = 4'd0;
    localparam logic [STATE_W-1:0] ST_LISTEN         = 4'd1;
    localparam logic [STATE_W-1:0] ST_SYN_SENT       = 4'd2;
    localparam logic [STATE_W-1:0] ST_SYN_RECV       = 4'd3;
    localparam logic [STATE_W-1:0] ST_ESTABLISHED    = 4'd4;
    localparam logic [STATE_W-1:0] ST_FIN_WAIT_1     = 4'd5;
    localparam logic [STATE_W-1:0] ST_FIN_WAIT_2     = 4'd6;
    localparam logic [STATE_W-1:0] ST_CLOSING        = 4'd7;
    localparam logic [STATE_W-1:0] ST_CLOSE_WAIT     = 4'd8;
    localparam logic [STATE_W-1:0] ST_WAIT_FINAL_ACK = 4'd9;

    // Configuration register indexes and reset values
    localparam logic [CFG_IDX_W-1:0] CFG_CLIENT_ISS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SERVER_ISS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_SEQ  = 2'd2;

    localparam logic [SEQ_W-1:0] CLIENT_ISS_RST = 32'd0;
    localparam logic [SEQ_W-1:0] SERVER_ISS_RST = 32'd0;
    localparam logic [SEQ_W-1:0] CLOSE_SEQ_RST  = 32'd1;

    // Input word
    typedef struct packed {
        logic [REQ_W-1:0]   req_type;
        logic [FLAGS_W-1:0] seg_flags;
        logic [SEQ_W-1:0]   seg_seq;
        logic [SEQ_W-1:0]   seg_ack;
    } req_t;

    // Result word
    typedef struct packed {
        logic               send_valid;
        logic [FLAGS_W-1:0] send_flags;
        logic [SEQ_W-1:0]   send_seq;
        logic [SEQ_W-1:0]   send_ack;
        logic [STATE_W-1:0] conn_status;
        logic               became_established;
        logic               last_result;
    } rsp_t;

    // Queue entry: first result plus a flag for the automatic FIN that follows
    typedef struct packed {
        rsp_t rsp;
        logic auto_fin;
    } entry_t;

endpackage

`default_nettype wire

/* sv/tcsm_front.sv */
`default_nettype none

module tcsm_front
(
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               accept,
    input  tcsm_pkg::req_t                    req,
    input  wire                               cfg_we,
    input  wire  [tcsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [tcsm_pkg::SEQ_W-1:0]        cfg_data,
    output tcsm_pkg::entry_t                  entry
);

    logic [tcsm_pkg::STATE_W-1:0] state_reg;
    logic [tcsm_pkg::STATE_W-1:0] state_next;
    logic [tcsm_pkg::SEQ_W-1:0]   client_iss_reg;
    logic [tcsm_pkg::SEQ_W-1:0]   server_iss_reg;
    logic [tcsm_pkg::SEQ_W-1:0]   close_seq_reg;
    logic [tcsm_pkg::SEQ_W-1:0]   seq_inc;
    logic [tcsm_pkg::SEQ_W-1:0]   close_inc;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            client_iss_reg <= tcsm_pkg::CLIENT_ISS_RST;
            server_iss_reg <= tcsm_pkg::SERVER_ISS_RST;
            close_seq_reg  <= tcsm_pkg::CLOSE_SEQ_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tcsm_pkg::CFG_CLIENT_ISS: client_iss_reg <= cfg_data;
                tcsm_pkg::CFG_SERVER_ISS: server_iss_reg <= cfg_data;
                tcsm_pkg::CFG_CLOSE_SEQ:  close_seq_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    assign seq_inc   = req.seg_seq + 32'd1;
    assign close_inc = close_seq_reg + 32'd1;

    // Classify the request and work out the first result word
    always_comb
    begin
        state_next                   = state_reg;
        entry                        = '0;
        entry.rsp.last_result        = 1'b1;
        case (req.req_type)
            tcsm_pkg::REQ_ACTIVE:
            begin
                if (state_reg == tcsm_pkg::ST_CLOSED)
                begin
                    entry.rsp.send_valid = 1'b1;
                    entry.rsp.send_flags = tcsm_pkg::FL_SYN;
                    entry.rsp.send_seq   = client_iss_reg;
                    state_next           = tcsm_pkg::ST_SYN_SENT;
                end
            end
            tcsm_pkg::REQ_PASSIVE:
            begin
                if (state_reg == tcsm_pkg::ST_CLOSED)
                    state_next = tcsm_pkg::ST_LISTEN;
            end
            tcsm_pkg::REQ_CLOSE:
            begin
                if (state_reg == tcsm_pkg::ST_ESTABLISHED ||
                    state_reg == tcsm_pkg::ST_CLOSE_WAIT)
                begin
                    entry.rsp.send_valid = 1'b1;
                    entry.rsp.send_flags = tcsm_pkg::FL_FIN_ACK;
                    entry.rsp.send_seq   = close_seq_reg;
                    state_next = (state_reg == tcsm_pkg::ST_ESTABLISHED) ?
                                 tcsm_pkg::ST_FIN_WAIT_1 : tcsm_pkg::ST_WAIT_FINAL_ACK;
                end
            end
            default:
            begin
                // received segment
                case (state_reg)
                    tcsm_pkg::ST_LISTEN:
                    begin
                        if (req.seg_flags == tcsm_pkg::FL_SYN)
                        begin
                            entry.rsp.send_valid = 1'b1;
                            entry.rsp.send_flags = tcsm_pkg::FL_SYN_ACK;
                            entry.rsp.send_seq   = server_iss_reg;
                            entry.rsp.send_ack   = seq_inc;
                            state_next           = tcsm_pkg::ST_SYN_RECV;
                        end
                    end
                    tcsm_pkg::ST_SYN_RECV:
                    begin
                        if (req.seg_flags == tcsm_pkg::FL_ACK)
                        begin
                            state_next                   = tcsm_pkg::ST_ESTABLISHED;
                            entry.rsp.became_established = 1'b1;
                        end
                    end
                    tcsm_pkg::ST_SYN_SENT:
                    begin
                        if (req.seg_flags == tcsm_pkg::FL_SYN_ACK)
                        begin
                            entry.rsp.send_valid         = 1'b1;
                            entry.rsp.send_flags         = tcsm_pkg::FL_ACK;
                            entry.rsp.send_seq           = req.seg_ack;
                            entry.rsp.send_ack           = seq_inc;
                            state_next                   = tcsm_pkg::ST_ESTABLISHED;
                            entry.rsp.became_established = 1'b1;
                        end
                    end
                    tcsm_pkg::ST_ESTABLISHED:
                    begin
                        // peer close: ACK now, our FIN follows from the back end
                        if (req.seg_flags == tcsm_pkg::FL_FIN_ACK)
                        begin
                            entry.rsp.send_valid  = 1'b1;
                            entry.rsp.send_flags  = tcsm_pkg::FL_ACK;
                            entry.rsp.send_seq    = close_seq_reg;
                            entry.rsp.send_ack    = seq_inc;
                            entry.rsp.conn_status = tcsm_pkg::ST_CLOSE_WAIT;
                            entry.rsp.last_result = 1'b0;
                            entry.auto_fin        = 1'b1;
                            state_next            = tcsm_pkg::ST_WAIT_FINAL_ACK;
                        end
                    end
                    tcsm_pkg::ST_FIN_WAIT_1:
                    begin
                        if (req.seg_flags == tcsm_pkg::FL_ACK)
                            state_next = tcsm_pkg::ST_FIN_WAIT_2;
                        else if (req.seg_flags == tcsm_pkg::FL_FIN_ACK)
                        begin
                            entry.rsp.send_valid = 1'b1;
                            entry.rsp.send_flags = tcsm_pkg::FL_ACK;
                            entry.rsp.send_seq   = close_inc;
                            entry.rsp.send_ack   = seq_inc;
                            state_next           = tcsm_pkg::ST_CLOSING;
                        end
                    end
                    tcsm_pkg::ST_FIN_WAIT_2:
                    begin
                        if (req.seg_flags == tcsm_pkg::FL_FIN_ACK)
                        begin
                            entry.rsp.send_valid = 1'b1;
                            entry.rsp.send_flags = tcsm_pkg::FL_ACK;
                            entry.rsp.send_seq   = req.seg_ack;
                            entry.rsp.send_ack   = seq_inc;
                            state_next           = tcsm_pkg::ST_CLOSED;
                        end
                    end
                    tcsm_pkg::ST_CLOSING,
                    tcsm_pkg::ST_WAIT_FINAL_ACK:
                    begin
                        if (req.seg_flags == tcsm_pkg::FL_ACK)
                            state_next = tcsm_pkg::ST_CLOSED;
                    end
                    default: ;
                endcase
            end
        endcase
        if (!entry.auto_fin)
            entry.rsp.conn_status = state_next;
    end

    // Connection state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= tcsm_pkg::ST_CLOSED;
        else if (accept)
            state_reg <= state_next;
    end

`ifndef ASSERT_OFF
    // state never leaves the defined codes
    a_state_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg <= tcsm_pkg::ST_WAIT_FINAL_ACK)
        else $error("connection state out of range");

    // the automatic FIN is only scheduled on the way to the final ACK wait
    a_auto_fin_state: assert property (@(posedge clk) disable iff (!rst_n)
        accept && entry.auto_fin |=> state_reg == tcsm_pkg::ST_WAIT_FINAL_ACK)
        else $error("automatic FIN without final ACK wait");
`endif

endmodule

`default_nettype wire

/* sv/tcsm_fifo.sv */
`default_nettype none

module tcsm_fifo
#(
    parameter int DEPTH = tcsm_pkg::QUEUE_DEPTH
)
(
    input  wire                clk,
    input  wire                rst_n,
    input  wire                push,
    input  tcsm_pkg::entry_t   push_data,
    input  wire                pop,
    output tcsm_pkg::entry_t   pop_data,
    output logic               full,
    output logic               empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tcsm_pkg::entry_t     mem_reg [DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem_reg[rd_ptr_reg];

    // storage, no reset
    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= push_data;
    end

    // pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

`ifndef ASSERT_OFF
    // no overflow or underflow of the queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop) && !(pop && empty))
        else $error("queue overflow or underflow");
`endif

endmodule

`default_nettype wire

/* sv/tcsm_back.sv */
`default_nettype none

module tcsm_back
(
    input  wire                clk,
    input  wire                rst_n,
    input  tcsm_pkg::entry_t   q_data,
    input  wire                q_empty,
    output logic               q_pop,
    output logic               rsp_valid,
    input  wire                rsp_stall,
    output tcsm_pkg::rsp_t     rsp
);

    logic                        out_valid_reg;
    tcsm_pkg::rsp_t              out_reg;
    logic                        fin_pend_reg;
    logic [tcsm_pkg::SEQ_W-1:0]  fin_seq_reg;
    logic                        load;

    // output register is free when empty or its word is being taken
    assign load      = !out_valid_reg || !rsp_stall;
    assign q_pop     = load && !fin_pend_reg && !q_empty;
    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            fin_pend_reg  <= 1'b0;
        end
        else if (load)
        begin
            if (fin_pend_reg)
            begin
                out_valid_reg <= 1'b1;
                fin_pend_reg  <= 1'b0;
            end
            else
            begin
                out_valid_reg <= !q_empty;
                fin_pend_reg  <= !q_empty && q_data.auto_fin;
            end
        end
    end

    // output word and the held FIN sequence number
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (fin_pend_reg)
            begin
                out_reg.send_valid         <= 1'b1;
                out_reg.send_flags         <= tcsm_pkg::FL_FIN_ACK;
                out_reg.send_seq           <= fin_seq_reg;
                out_reg.send_ack           <= '0;
                out_reg.conn_status        <= tcsm_pkg::ST_WAIT_FINAL_ACK;
                out_reg.became_established <= 1'b0;
                out_reg.last_result        <= 1'b1;
            end
            else if (!q_empty)
            begin
                out_reg     <= q_data.rsp;
                fin_seq_reg <= q_data.rsp.send_seq;
            end
        end
    end

`ifndef ASSERT_OFF
    // a pending FIN always sits behind a word in the output register
    a_pend_has_word: assert property (@(posedge clk) disable iff (!rst_n)
        fin_pend_reg |-> out_valid_reg && !out_reg.last_result)
        else $error("pending FIN without first word");

    // after a non-final word is taken, the final one is shown next
    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !rsp_stall && !out_reg.last_result
        |=> out_valid_reg && out_reg.last_result)
        else $error("second result missing");
`endif

endmodule

`default_nettype wire

/* sv/tcp_connection_state_machine_core.sv */
`default_nettype none

// TCP connection state machine for one connection, control segments only.
// A request word (received segment, active open, passive open or close) is
// taken in every cycle while req_stall is low; req_stall rises only when the
// QUEUE_DEPTH-entry queue between the front end and the output stage is full.
// The front end updates the connection state in the cycle of acceptance, so
// requests may follow each other back to back. Each request yields one
// result word, which goes through the queue and then the output register
// before it appears on rsp; a FIN+ACK received in ESTABLISHED yields two
// (an ACK, then our own FIN+ACK), and the output stage pops no queue entry
// while our FIN+ACK is pending, so a run of those can fill the queue and
// stall requests. Registers are written through cfg_we, cfg_index and
// cfg_data and should be changed only while no request is in flight.
module tcp_connection_state_machine_core
#(
    parameter int QUEUE_DEPTH = tcsm_pkg::QUEUE_DEPTH
)
(
    input  wire                               clk,
    input  wire                               rst_n,
    input  wire                               req_valid,
    output logic                              req_stall,
    input  tcsm_pkg::req_t                    req,
    output logic                              rsp_valid,
    input  wire                               rsp_stall,
    output tcsm_pkg::rsp_t                    rsp,
    input  wire                               cfg_we,
    input  wire  [tcsm_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire  [tcsm_pkg::SEQ_W-1:0]        cfg_data
);

    logic               accept;
    logic               q_full;
    logic               q_empty;
    logic               q_pop;
    tcsm_pkg::entry_t   front_entry;
    tcsm_pkg::entry_t   q_data;

    assign req_stall = q_full;
    assign accept    = req_valid && !q_full;

    // request decode and state update
    tcsm_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .accept    (accept),
        .req       (req),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .entry     (front_entry)
    );

    // queue between front end and output stage
    tcsm_fifo
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_fifo
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (accept),
        .push_data (front_entry),
        .pop       (q_pop),
        .pop_data  (q_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    // result words out
    tcsm_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_data    (q_data),
        .q_empty   (q_empty),
        .q_pop     (q_pop),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule

`default_nettype wire
